// ===== design/goodness_epoch_scheduler_defines.svh =====
// Assertion macros for the goodness epoch scheduler checker.
// Every macro samples on i_clk; the first two are disabled while i_rst_n is low.
`ifndef GOODNESS_EPOCH_SCHEDULER_DEFINES_SVH
`define GOODNESS_EPOCH_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GEPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GEPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define GEPS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/geps_pkg.sv =====
// Shared types and codes for the goodness epoch scheduler.
// No dependencies; used by the top level, the scan unit and the checker.
package geps_pkg;

    localparam logic OP_RESCHED   = 1'b0;
    localparam logic OP_SET_ENTRY = 1'b1;

    localparam logic [1:0] RUN_FREE    = 2'd0;
    localparam logic [1:0] RUN_CURRENT = 2'd1;
    localparam logic [1:0] RUN_READY   = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [8:0] leftover_ticks;
        logic [5:0] slot;
        logic [7:0] priority_req;
        logic [1:0] run_state;
    } t_sched_in;

    typedef struct packed {
        logic       is_schedule;
        logic [5:0] chosen_slot;
        logic [8:0] load_ticks;
        logic       epoch_started;
    } t_sched_out;

    typedef struct packed {
        logic [7:0] prio;
        logic [1:0] run_state;
        logic [9:0] goodness;
        logic [8:0] remaining;
    } t_slot_entry;

    typedef struct packed {
        logic write_back;
        logic take;
        logic positive;
    } t_scan_res;

endpackage

// ===== design/geps_scan_unit.sv =====
// Per-slot evaluation unit shared by every step of the table scan.
// Depends on geps_pkg for the slot entry and scan result types.
module geps_scan_unit (
    input  geps_pkg::t_slot_entry i_entry,
    input  logic                  i_idx_zero,
    input  logic                  i_refill,
    input  logic [9:0]            i_best_good,
    output geps_pkg::t_slot_entry o_entry,
    output geps_pkg::t_scan_res   o_res
);
    import geps_pkg::*;

    logic [8:0] quantum;
    logic [9:0] good_new;
    logic       refill_hit;

    always_comb begin
        quantum    = {1'b0, i_entry.prio} + {1'b0, i_entry.remaining[8:1]};
        good_new   = {2'b00, i_entry.prio} + {1'b0, quantum};
        refill_hit = i_refill && !i_idx_zero && (i_entry.run_state != RUN_FREE);

        o_entry = i_entry;
        if (refill_hit) begin
            o_entry.remaining = quantum;
            o_entry.goodness  = good_new;
        end

        o_res.write_back = refill_hit;
        o_res.positive   = (o_entry.run_state != RUN_FREE) && (o_entry.goodness != 10'd0);
        // Slot 0 wins only on positive goodness; later slots win ties.
        if (o_entry.run_state != RUN_READY) begin
            o_res.take = 1'b0;
        end else if (i_idx_zero) begin
            o_res.take = (o_entry.goodness != 10'd0);
        end else begin
            o_res.take = (o_entry.goodness >= i_best_good);
        end
    end

endmodule

// ===== design/goodness_epoch_scheduler.sv =====
// Goodness epoch scheduler top level: slot table memory, sequencer, output register.
// Depends on geps_pkg and geps_scan_unit.
//
// A set_entry transaction goes from acceptance through the update state to the output state,
// where its result is loaded. A reschedule runs update, one scan pass, finish and output when
// the epoch goes on, and adds a refill pass when a new epoch starts: the table sits in one
// memory with one read and one write port, and each pass reads one slot per cycle through the
// shared scan unit. The first pass checks for exhaustion and picks a winner at once; the refill
// pass rewrites quanta and picks again. The block takes no new transaction until its result is
// loaded into the output register, which then waits on its own for the consumer. Per-slot valid
// bits return the reset values for untouched slots, so no clearing pass runs after reset.
module goodness_epoch_scheduler #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  geps_pkg::t_sched_in  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output geps_pkg::t_sched_out o_out_data
);
    import geps_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = SW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_OUTPUT = 3'd4;

    logic [2:0]      r_state;
    t_sched_in       r_req;
    logic [SW-1:0]   r_req_idx;
    logic            r_in_range;
    logic [SW-1:0]   r_running;

    t_slot_entry     r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    t_slot_entry     r_rd_data;
    logic            r_rd_ok;

    logic [CW-1:0]   r_idx;
    logic            r_dv;
    logic [SW-1:0]   r_didx;
    logic            r_refill;
    logic            r_any_pos;
    logic            r_epoch;
    logic [9:0]      r_best_good;
    logic [SW-1:0]   r_best_idx;
    t_slot_entry     r_best_entry;

    t_sched_out      r_res;
    logic            r_out_valid;
    t_sched_out      r_out_data;

    logic            in_fire;
    logic            req_in_range;
    logic [SW+5:0]   slot_ext;
    logic [SW-1:0]   acc_idx;
    logic            rd_en;
    logic [SW-1:0]   rd_addr;
    logic            wr_en;
    logic [SW-1:0]   wr_addr;
    t_slot_entry     wr_data;
    t_slot_entry     eff;
    t_slot_entry     upd;
    t_slot_entry     scan_entry;
    t_scan_res       scan_res;
    logic [9:0]      cur_good;
    logic            issue;
    logic            last;
    logic [SW+5:0]   best_ext;
    logic [SW+5:0]   run_ext;
    t_sched_out      sched_res;
    t_sched_out      ack_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_fire      = i_in_valid && o_in_ready;
    assign req_in_range = (32'(i_in_data.slot) < SLOT_COUNT);
    assign slot_ext     = {{SW{1'b0}}, i_in_data.slot};
    assign acc_idx      = (i_in_data.opcode == OP_SET_ENTRY) ? slot_ext[SW-1:0] : r_running;

    assign issue = (r_idx < CW'(SLOT_COUNT));
    assign last  = (r_didx == SW'(SLOT_COUNT - 1));

    // Untouched slots read as their reset value: all zero, state free.
    assign eff      = r_rd_ok ? r_rd_data : '0;
    assign cur_good = {2'b00, eff.prio} + {1'b0, r_req.leftover_ticks};

    always_comb begin
        upd = eff;
        if (r_req.opcode == OP_SET_ENTRY) begin
            upd.prio      = r_req.priority_req;
            upd.run_state = r_req.run_state;
        end else begin
            if (r_req_idx != '0) begin
                upd.remaining = r_req.leftover_ticks;
                upd.goodness  = (r_req.leftover_ticks == 9'd0) ? 10'd0 : cur_good;
            end
            if (eff.run_state == RUN_CURRENT) begin
                upd.run_state = RUN_READY;
            end
        end
    end

    geps_scan_unit u_scan (
        .i_entry     (eff),
        .i_idx_zero  (r_didx == '0),
        .i_refill    (r_refill),
        .i_best_good (r_best_good),
        .o_entry     (scan_entry),
        .o_res       (scan_res)
    );

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[SW-1:0];
        if (r_state == S_IDLE) begin
            rd_addr = acc_idx;
            rd_en   = in_fire && ((i_in_data.opcode == OP_RESCHED) || req_in_range);
        end else if (r_state == S_SCAN) begin
            rd_en = issue;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = scan_entry;
        case (r_state)
            S_UPDATE: begin
                wr_addr = r_req_idx;
                wr_data = upd;
                wr_en   = (r_req.opcode == OP_RESCHED) || r_in_range;
            end
            S_SCAN: begin
                wr_en = r_dv && scan_res.write_back;
            end
            S_FINISH: begin
                wr_addr           = r_best_idx;
                wr_data           = r_best_entry;
                wr_data.run_state = RUN_CURRENT;
                wr_en             = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        best_ext  = {6'b0, r_best_idx};
        run_ext   = {6'b0, r_running};
        sched_res = '{is_schedule: 1'b1, chosen_slot: best_ext[5:0],
                      load_ticks: r_best_entry.remaining, epoch_started: r_epoch};
        ack_res   = '{is_schedule: 1'b0, chosen_slot: run_ext[5:0],
                      load_ticks: 9'd0, epoch_started: 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            // Drop the result once taken, unless the next one loads in the same cycle.
            if (r_out_valid && i_out_ready && (r_state != S_OUTPUT)) begin
                r_out_valid <= 1'b0;
            end
            r_dv   <= (r_state == S_SCAN) && issue;
            r_didx <= r_idx[SW-1:0];
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req      <= i_in_data;
                        r_req_idx  <= acc_idx;
                        r_in_range <= req_in_range;
                        r_state    <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_req.opcode == OP_SET_ENTRY) begin
                        r_res   <= ack_res;
                        r_state <= S_OUTPUT;
                    end else begin
                        r_idx       <= '0;
                        r_refill    <= 1'b0;
                        r_any_pos   <= 1'b0;
                        r_epoch     <= 1'b0;
                        r_best_good <= '0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_dv) begin
                        if (scan_res.positive) begin
                            r_any_pos <= 1'b1;
                        end
                        // Slot 0 seeds the winner; its goodness counts only if it takes.
                        if (r_didx == '0) begin
                            r_best_idx   <= '0;
                            r_best_entry <= scan_entry;
                            r_best_good  <= scan_res.take ? scan_entry.goodness : 10'd0;
                        end else if (scan_res.take) begin
                            r_best_idx   <= r_didx;
                            r_best_entry <= scan_entry;
                            r_best_good  <= scan_entry.goodness;
                        end
                        if (last) begin
                            if (r_refill || r_any_pos || scan_res.positive) begin
                                r_state <= S_FINISH;
                            end else begin
                                // Epoch exhausted: rescan with refill.
                                r_refill  <= 1'b1;
                                r_epoch   <= 1'b1;
                                r_any_pos <= 1'b0;
                                r_idx     <= '0;
                            end
                        end
                    end
                end
                S_FINISH: begin
                    r_running <= r_best_idx;
                    r_res     <= sched_res;
                    r_state   <= S_OUTPUT;
                end
                S_OUTPUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/geps_checker.sv =====
// Port-level checker for the goodness epoch scheduler, bound to the top level.
// Depends on geps_pkg and goodness_epoch_scheduler_defines.svh.
`include "goodness_epoch_scheduler_defines.svh"

module geps_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input geps_pkg::t_sched_in  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input geps_pkg::t_sched_out o_out_data
);

    `GEPS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    `GEPS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready held high right after a transaction")

    `GEPS_ASSERT_SAME(a_ack_clean, o_out_valid && !o_out_data.is_schedule, o_out_data.load_ticks == 9'd0 && !o_out_data.epoch_started, "set_entry acknowledgement carries ticks or epoch flag")

    `GEPS_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_out_valid && o_in_ready, "block not idle after reset")

endmodule

bind goodness_epoch_scheduler geps_checker u_geps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
